FILE: design/encoder_speed_sampler_top_macros.svh
// Assertion macros used by the checker file of the encoder speed sampler.
`ifndef ENCODER_SPEED_SAMPLER_TOP_MACROS_SVH
`define ENCODER_SPEED_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ess check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ESS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ess check failed");

`endif

FILE: design/ess_pkg.sv
`default_nettype none

package ess_pkg;

  localparam int unsigned CounterWidthDef = 16;

  localparam int unsigned CENTER_COUNT  = 32768;
  localparam int unsigned MAX_SAMPLE_MS = 50;
  localparam int unsigned DELTA_MARGIN  = 8;
  localparam int unsigned MS_PER_MIN    = 60000;

  localparam int unsigned CPR_W      = 16;
  localparam int unsigned RPM_W      = 15;
  localparam int unsigned CIRC_W     = 20;
  localparam int unsigned PERIOD_W   = 6;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CPR_W-1:0]    CPR_RST    = 16'd1024;
  localparam logic [RPM_W-1:0]    RPM_RST    = 15'd600;
  localparam logic [CIRC_W-1:0]   CIRC_RST   = 20'd200000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 6'd10;

  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned DIV_STEP_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPR    = 2'd0,
    CFG_RPM    = 2'd1,
    CFG_CIRC   = 2'd2,
    CFG_PERIOD = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_CHECK,
    OP_DIV,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [2:0] {
    MS_CPR_RPM,
    MS_LIMIT,
    MS_LHS,
    MS_NUM,
    MS_DEN
  } mul_step_e;

  typedef struct packed {
    dp_op_e                 op;
    mul_step_e              mstep;
    logic [DIV_STEP_W-1:0]  dstep;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/ess_intf.sv
`default_nettype none

interface ess_in_if #(
  parameter int unsigned COUNTER_WIDTH = ess_pkg::CounterWidthDef
);
  logic                     valid;
  logic                     ready;
  logic [COUNTER_WIDTH-1:0] counter_value;
  logic [31:0]              now_ms;

  modport source (output valid, output counter_value, output now_ms, input ready);
  modport sink   (input valid, input counter_value, input now_ms, output ready);
endinterface

interface ess_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] delta_counts;
  logic signed [15:0] speed_mmps;
  logic signed [31:0] total_counts;
  logic               sample_valid;

  modport source (output valid, output delta_counts, output speed_mmps,
                  output total_counts, output sample_valid, input ready);
  modport sink   (input valid, input delta_counts, input speed_mmps,
                  input total_counts, input sample_valid, output ready);
endinterface

`default_nettype wire

FILE: design/ess_ctrl.sv
`default_nettype none

module ess_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire ess_pkg::dp_status_t status_i,
  output logic                    in_ready_o,
  output ess_pkg::dp_cmd_t        cmd_o
);

  ess_pkg::ctrl_state_e                state_q, state_d;
  ess_pkg::mul_step_e                  mstep_q, mstep_d;
  logic [ess_pkg::DIV_STEP_W-1:0]      dstep_q, dstep_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ess_pkg::ST_IDLE;
      mstep_q <= ess_pkg::MS_CPR_RPM;
      dstep_q <= '0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      dstep_q <= dstep_d;
    end
  end

  // Next state and step counters.
  always_comb begin
    state_d = state_q;
    mstep_d = mstep_q;
    dstep_d = dstep_q;
    unique case (state_q)
      ess_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ess_pkg::ST_MUL;
          mstep_d = ess_pkg::MS_CPR_RPM;
        end
      end
      ess_pkg::ST_MUL: begin
        if (mstep_q == ess_pkg::MS_DEN) begin
          state_d = ess_pkg::ST_CHECK;
        end else begin
          mstep_d = ess_pkg::mul_step_e'(mstep_q + 3'd1);
        end
      end
      ess_pkg::ST_CHECK: begin
        state_d = ess_pkg::ST_DIV;
        dstep_d = ess_pkg::DIV_STEP_W'(ess_pkg::DIV_STEPS - 1);
      end
      ess_pkg::ST_DIV: begin
        if (dstep_q == '0) begin
          state_d = ess_pkg::ST_FINISH;
        end else begin
          dstep_d = dstep_q - 1'b1;
        end
      end
      ess_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ess_pkg::ST_IDLE;
        end
      end
      default: state_d = ess_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = ess_pkg::OP_NONE;
    cmd_o.mstep = mstep_q;
    cmd_o.dstep = dstep_q;
    unique case (state_q)
      ess_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ess_pkg::OP_LOAD;
        end
      end
      ess_pkg::ST_MUL:   cmd_o.op = ess_pkg::OP_MUL;
      ess_pkg::ST_CHECK: cmd_o.op = ess_pkg::OP_CHECK;
      ess_pkg::ST_DIV:   cmd_o.op = ess_pkg::OP_DIV;
      ess_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.op = ess_pkg::OP_FINISH;
        end
      end
      default: cmd_o.op = ess_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ess_dp.sv
`default_nettype none

module ess_dp #(
  parameter int unsigned COUNTER_WIDTH = ess_pkg::CounterWidthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ess_pkg::dp_cmd_t                   cmd_i,
  output ess_pkg::dp_status_t                     status_o,
  input  wire logic [COUNTER_WIDTH-1:0]           counter_value_i,
  input  wire logic [31:0]                        now_ms_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [ess_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ess_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic signed [15:0]                      delta_counts_o,
  output logic signed [15:0]                      speed_mmps_o,
  output logic signed [31:0]                      total_counts_o,
  output logic                                    sample_valid_o
);

  localparam int unsigned MAG_W  = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
  localparam int unsigned DLT_W  = MAG_W + 1;
  localparam int unsigned PROD_W = ess_pkg::CPR_W + ess_pkg::RPM_W;
  localparam int unsigned LIM_W  = PROD_W + ess_pkg::PERIOD_W;
  localparam int unsigned LHS_W  = MAG_W + 16;
  localparam int unsigned NUM_W  = MAG_W + ess_pkg::CIRC_W;
  localparam int unsigned DEN_W  = ess_pkg::CPR_W + ess_pkg::PERIOD_W;
  localparam int unsigned MA_W   = (MAG_W > PROD_W) ? MAG_W : PROD_W;
  localparam int unsigned MB_W   = ess_pkg::CIRC_W;
  localparam int unsigned MP_W   = MA_W + MB_W;
  localparam int unsigned CMPL_W = (LHS_W > LIM_W) ? LHS_W : LIM_W;
  localparam int unsigned CMP_W  = NUM_W + DEN_W;
  localparam int unsigned TW     = ((DLT_W > 32) ? DLT_W : 32) + 1;
  localparam int unsigned QW     = ess_pkg::DIV_STEPS;

  localparam logic signed [TW-1:0] TotMax = (TW'(1) << 31) - TW'(1);
  localparam logic signed [TW-1:0] TotMin = -(TW'(1) << 31);

  // Configuration and persistent state.
  logic [ess_pkg::CPR_W-1:0]    cpr_q;
  logic [ess_pkg::RPM_W-1:0]    rpm_q;
  logic [ess_pkg::CIRC_W-1:0]   circ_q;
  logic [ess_pkg::PERIOD_W-1:0] period_q;
  logic [31:0]                  last_q;
  logic signed [31:0]           total_q;
  logic                         out_valid_q;

  // Per-word working registers.
  logic signed [DLT_W-1:0] delta_q;
  logic [MAG_W-1:0]        mag_q;
  logic [31:0]             elapsed_q;
  logic                    pre_ok_q;
  logic                    ok_q;
  logic                    ovf_q;
  logic [PROD_W-1:0]       prod_q;
  logic [LIM_W-1:0]        lim_q;
  logic [LHS_W-1:0]        lhs_q;
  logic [NUM_W-1:0]        num_q;
  logic [DEN_W-1:0]        den_q;
  logic [NUM_W-1:0]        rem_q;
  logic [QW-1:0]           quo_q;

  logic signed [15:0] delta_out_q, speed_out_q;
  logic               samp_out_q;

  // Load stage.
  logic signed [DLT_W-1:0] delta_d;
  logic [DLT_W-1:0]        abs_d;
  logic [31:0]             elapsed_d;
  logic                    pre_ok_d;

  always_comb begin
    delta_d   = $signed(DLT_W'(counter_value_i)) - $signed(DLT_W'(ess_pkg::CENTER_COUNT));
    abs_d     = (delta_d < 0) ? DLT_W'(-delta_d) : DLT_W'(delta_d);
    elapsed_d = (last_q == 32'd0) ? 32'(period_q) : (now_ms_i - last_q);
    pre_ok_d  = (elapsed_d != 32'd0) && (elapsed_d <= 32'(ess_pkg::MAX_SAMPLE_MS)) &&
                (cpr_q != '0);
  end

  // Shared multiplier, operands chosen by the step.
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mstep)
      ess_pkg::MS_CPR_RPM: begin
        mul_a = MA_W'(cpr_q);
        mul_b = MB_W'(rpm_q);
      end
      ess_pkg::MS_LIMIT: begin
        mul_a = MA_W'(prod_q);
        mul_b = MB_W'(elapsed_q[ess_pkg::PERIOD_W-1:0]);
      end
      ess_pkg::MS_LHS: begin
        // (mag - margin) * 60000 against the exact limit product
        mul_a = (mag_q > MAG_W'(ess_pkg::DELTA_MARGIN)) ?
                MA_W'(mag_q - MAG_W'(ess_pkg::DELTA_MARGIN)) : '0;
        mul_b = MB_W'(ess_pkg::MS_PER_MIN);
      end
      ess_pkg::MS_NUM: begin
        mul_a = MA_W'(mag_q);
        mul_b = MB_W'(circ_q);
      end
      ess_pkg::MS_DEN: begin
        mul_a = MA_W'(cpr_q);
        mul_b = MB_W'(elapsed_q[ess_pkg::PERIOD_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = MP_W'(mul_a) * MP_W'(mul_b);
  end

  // Division trial and finish values.
  logic [CMP_W-1:0]     trial;
  logic                 fits;
  logic                 too_fast;
  logic signed [TW-1:0] sum;
  logic signed [31:0]   total_sat;
  logic signed [15:0]   speed_d;

  always_comb begin
    trial    = CMP_W'(den_q) << cmd_i.dstep;
    fits     = CMP_W'(rem_q) >= trial;
    too_fast = CMPL_W'(lhs_q) > CMPL_W'(lim_q);
    sum      = TW'(total_q) + TW'(delta_q);
    if (sum > TotMax) begin
      total_sat = 32'sh7FFFFFFF;
    end else if (sum < TotMin) begin
      total_sat = -32'sh7FFFFFFF - 32'sd1;
    end else begin
      total_sat = 32'(sum);
    end
    if (delta_q < 0) begin
      if (ovf_q || (quo_q > QW'(32768))) begin
        speed_d = -16'sd32767 - 16'sd1;
      end else begin
        speed_d = $signed(16'(~quo_q + 1'b1));
      end
    end else begin
      if (ovf_q || (quo_q > QW'(32767))) begin
        speed_d = 16'sd32767;
      end else begin
        speed_d = $signed(16'(quo_q));
      end
    end
  end

  // Configuration, persistent state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q       <= ess_pkg::CPR_RST;
      rpm_q       <= ess_pkg::RPM_RST;
      circ_q      <= ess_pkg::CIRC_RST;
      period_q    <= ess_pkg::PERIOD_RST;
      last_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (ess_pkg::cfg_idx_e'(cfg_idx_i))
          ess_pkg::CFG_CPR:    cpr_q    <= cfg_data_i[ess_pkg::CPR_W-1:0];
          ess_pkg::CFG_RPM:    rpm_q    <= cfg_data_i[ess_pkg::RPM_W-1:0];
          ess_pkg::CFG_CIRC:   circ_q   <= cfg_data_i[ess_pkg::CIRC_W-1:0];
          ess_pkg::CFG_PERIOD: period_q <= cfg_data_i[ess_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == ess_pkg::OP_LOAD) begin
        last_q <= now_ms_i;
      end
      if (cmd_i.op == ess_pkg::OP_FINISH) begin
        out_valid_q <= 1'b1;
        if (ok_q) begin
          total_q <= total_sat;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ess_pkg::OP_LOAD: begin
        delta_q   <= delta_d;
        mag_q     <= MAG_W'(abs_d);
        elapsed_q <= elapsed_d;
        pre_ok_q  <= pre_ok_d;
      end
      ess_pkg::OP_MUL: begin
        unique case (cmd_i.mstep)
          ess_pkg::MS_CPR_RPM: prod_q <= PROD_W'(mul_p);
          ess_pkg::MS_LIMIT:   lim_q  <= LIM_W'(mul_p);
          ess_pkg::MS_LHS:     lhs_q  <= LHS_W'(mul_p);
          ess_pkg::MS_NUM:     num_q  <= NUM_W'(mul_p);
          ess_pkg::MS_DEN:     den_q  <= DEN_W'(mul_p);
          default: ;
        endcase
      end
      ess_pkg::OP_CHECK: begin
        ok_q  <= pre_ok_q && !too_fast;
        ovf_q <= CMP_W'(num_q) >= (CMP_W'(den_q) << QW);
        rem_q <= num_q;
        quo_q <= '0;
      end
      ess_pkg::OP_DIV: begin
        if (fits) begin
          rem_q              <= rem_q - NUM_W'(trial);
          quo_q[cmd_i.dstep] <= 1'b1;
        end
      end
      ess_pkg::OP_FINISH: begin
        samp_out_q <= ok_q;
        if (ok_q) begin
          delta_out_q <= $signed(delta_q[15:0]);
          speed_out_q <= speed_d;
        end else begin
          delta_out_q <= '0;
          speed_out_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign delta_counts_o    = delta_out_q;
  assign speed_mmps_o      = speed_out_q;
  assign total_counts_o    = total_q;
  assign sample_valid_o    = samp_out_q;

endmodule

`default_nettype wire

FILE: design/encoder_speed_sampler_top.sv
// Encoder speed sampler.
// in_ch carries one word per sample: the raw quadrature counter reading
// (centre 32768 means no motion) and the millisecond timestamp. out_ch
// returns one word per sample: count delta, speed in mm/s, running count
// total and the plausibility flag. Both channels move a word at a rising
// edge with valid and ready high.
// Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i, one register
// per edge: 0 counts per rev, 1 max rpm, 2 wheel circumference in um,
// 3 control period in ms. Write only while the block is idle.
// Each word is loaded at the accepting edge, then goes through five passes of
// the shared multiplier, one check, sixteen steps of the restoring divider
// and one finish, which waits until the output slot is free. The block takes
// a new word only once it is back in idle after the finish.
// Reset clears the running total and the last timestamp (so the first sample
// uses the control period) and loads the register defaults.
// A stalled receiver holds the result in the output register; the next word
// may be taken and processed, but its finish waits until the slot frees up.
`default_nettype none

module encoder_speed_sampler_top #(
  parameter int unsigned COUNTER_WIDTH = ess_pkg::CounterWidthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  ess_in_if.sink                              in_ch,
  ess_out_if.source                           out_ch,
  input  wire logic                           cfg_we_i,
  input  wire logic [ess_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ess_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ess_pkg::dp_cmd_t    cmd;
  ess_pkg::dp_status_t status;
  logic                in_ready;

  // Controller: sequences load, multiply passes, check, divide and finish.
  ess_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath: config, state, shared multiplier, divider and output register.
  ess_dp #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .counter_value_i (in_ch.counter_value),
    .now_ms_i        (in_ch.now_ms),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .delta_counts_o  (out_ch.delta_counts),
    .speed_mmps_o    (out_ch.speed_mmps),
    .total_counts_o  (out_ch.total_counts),
    .sample_valid_o  (out_ch.sample_valid)
  );

endmodule

`default_nettype wire

FILE: design/ess_checker.sv
`default_nettype none
`include "encoder_speed_sampler_top_macros.svh"

module ess_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] delta_i,
  input wire logic [15:0] speed_i,
  input wire logic [31:0] total_i,
  input wire logic        samp_valid_i
);

  // Hold a stalled result word.
  `ESS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ESS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable({delta_i, speed_i, total_i, samp_valid_i}))
  // One word in flight: drop ready right after a word is taken.
  `ESS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // A rejected sample reports zero delta and zero speed.
  `ESS_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni, out_valid_i && !samp_valid_i, (delta_i == 16'd0) && (speed_i == 16'd0))

endmodule

bind encoder_speed_sampler_top ess_checker u_ess_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .delta_i      (out_ch.delta_counts),
  .speed_i      (out_ch.speed_mmps),
  .total_i      (out_ch.total_counts),
  .samp_valid_i (out_ch.sample_valid)
);

`default_nettype wire
